// File: hdl/ubwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ubwt_pkg
// Shared types and codes of the unique bit-set worklist table.
// -----------------------------------------------------------------------------
package ubwt_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned SetBitsDef    = 64;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned InSetW    = 64;
  localparam int unsigned WidthW    = 7;
  localparam int unsigned OutIdxW   = 6;
  localparam int unsigned OutTotalW = 7;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned OutUserW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_ABSENT = 2'd0,
    CMD_PUSH        = 2'd1,
    CMD_POP         = 2'd2,
    CMD_LOOKUP      = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // scan token passed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

endpackage
`default_nettype wire

// File: hdl/ubwt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ubwt_cell
// One table entry plus one stage of the scan token that walks the row.
// -----------------------------------------------------------------------------
module ubwt_cell
  import ubwt_pkg::*;
#(
  parameter int unsigned CELL_INDEX = 0,
  parameter int unsigned SET_BITS   = SetBitsDef,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned CNT_W      = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tok_t                tok_i,
  input  wire logic [IDX_W-1:0]    idx_i,
  input  wire logic [SET_BITS-1:0] data_i,
  input  wire logic [SET_BITS-1:0] query_i,
  input  wire logic [SET_BITS-1:0] mask_i,
  input  wire logic [CNT_W-1:0]    count_i,
  input  wire logic [IDX_W-1:0]    pop_idx_i,
  input  wire logic                wr_en_i,
  input  wire logic [IDX_W-1:0]    wr_idx_i,
  input  wire logic [SET_BITS-1:0] wr_data_i,
  output tok_t                     tok_o,
  output logic [IDX_W-1:0]         idx_o,
  output logic [SET_BITS-1:0]      data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(CELL_INDEX);

  logic [SET_BITS-1:0] entry_q;
  tok_t                tok_q, tok_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SET_BITS-1:0] data_q, data_d;
  logic                match;

  assign match = tok_i.valid && !tok_i.hit && (MyCnt < count_i) &&
                 (((entry_q ^ query_i) & mask_i) == '0);

  always_comb begin
    tok_d.valid = tok_i.valid;
    tok_d.hit   = tok_i.hit | match;
    idx_d       = match ? MyIdx : idx_i;
    data_d      = (tok_i.valid && (pop_idx_i == MyIdx)) ? entry_q : data_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == MyIdx)) begin
      entry_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    data_q <= data_d;
  end

  assign tok_o  = tok_q;
  assign idx_o  = idx_q;
  assign data_o = data_q;

endmodule
`default_nettype wire

// File: hdl/ubwt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ubwt_ctrl
// Command sequencer: takes words, launches scans, updates the count, writes
// entries and holds the result word.
// -----------------------------------------------------------------------------
module ubwt_ctrl
  import ubwt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned SET_BITS    = SetBitsDef,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned CNT_W       = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InSetW-1:0]    s_axis_tdata,
  input  wire logic [CmdW-1:0]      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic [OutUserW-1:0]       m_axis_tuser,
  input  wire logic                 cfg_we_i,
  input  wire logic [WidthW-1:0]    cfg_wdata_i,
  output tok_t                      tok_o,
  output logic [SET_BITS-1:0]       query_o,
  output logic [SET_BITS-1:0]       mask_o,
  output logic [CNT_W-1:0]          count_o,
  output logic [IDX_W-1:0]          pop_idx_o,
  output logic                      wr_en_o,
  output logic [IDX_W-1:0]          wr_idx_o,
  output logic [SET_BITS-1:0]       wr_data_o,
  input  wire tok_t                 tok_i,
  input  wire logic [IDX_W-1:0]     idx_i,
  input  wire logic [SET_BITS-1:0]  data_i
);

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [WidthW-1:0]     set_width_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  launch_q, launch_d;
  cmd_e                  cmd_q;
  logic [InSetW-1:0]     set_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hidx_q;
  logic [SET_BITS-1:0]   hdata_q;
  logic                  m_valid_q, m_valid_d;
  logic [OutDataW-1:0]   m_data_q, m_data_d;
  logic [OutUserW-1:0]   m_user_q, m_user_d;
  logic                  accept;
  logic                  full;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  found;
  status_e               status;
  logic [SET_BITS-1:0]   popped;
  logic [IDX_W-1:0]      res_idx;
  logic [IDX_W+OutIdxW-1:0]     idx_ext;
  logic [CNT_W+OutTotalW-1:0]   cnt_ext;
  logic [SET_BITS+InSetW-1:0]   pop_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == DepthCnt);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cnt_m1        = count_q - 1'b1;

  always_comb begin
    for (int b = 0; b < SET_BITS; b++) begin
      mask_o[b] = (WidthW'(b) < set_width_q);
    end
  end

  assign tok_o     = '{valid: launch_q, hit: 1'b0};
  assign query_o   = set_q[SET_BITS-1:0];
  assign count_o   = count_q;
  assign pop_idx_o = cnt_m1[IDX_W-1:0];
  assign wr_idx_o  = count_q[IDX_W-1:0];
  assign wr_data_o = set_q[SET_BITS-1:0];

  always_comb begin
    state_d   = state_q;
    launch_d  = 1'b0;
    count_d   = count_q;
    wr_en_o   = 1'b0;
    found     = 1'b0;
    res_idx   = '0;
    popped    = '0;
    status    = STAT_OK;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    case (cmd_q)
      CMD_PUSH_ABSENT: begin
        if (hit_q) begin
          found   = 1'b1;
          res_idx = hidx_q;
        end else if (full) begin
          status = STAT_FULL;
        end else begin
          wr_en_o = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_PUSH: begin
        if (full) begin
          status = STAT_FULL;
        end else begin
          wr_en_o = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status = STAT_EMPTY;
        end else begin
          count_d = cnt_m1;
          popped  = hdata_q;
        end
      end
      default: begin
        if (hit_q) begin
          found   = 1'b1;
          res_idx = hidx_q;
        end
      end
    endcase

    idx_ext = {{OutIdxW{1'b0}}, res_idx};
    cnt_ext = {{OutTotalW{1'b0}}, count_d};
    pop_ext = {{InSetW{1'b0}}, popped};

    case (state_q)
      S_IDLE: begin
        wr_en_o = 1'b0;
        count_d = count_q;
        if (accept) begin
          if (cmd_e'(s_axis_tuser) == CMD_PUSH) begin
            state_d = S_FINISH;
          end else begin
            launch_d = 1'b1;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        wr_en_o = 1'b0;
        count_d = count_q;
        if (tok_i.valid) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {(OutDataW - OutIdxW - InSetW - OutTotalW)'(0),
                       cnt_ext[OutTotalW-1:0], pop_ext[InSetW-1:0],
                       idx_ext[OutIdxW-1:0]};
          m_user_d  = {status, found};
          state_d   = S_IDLE;
        end else begin
          wr_en_o = 1'b0;
          count_d = count_q;
        end
      end
      default: begin
        wr_en_o = 1'b0;
        count_d = count_q;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      set_width_q <= WidthW'(64);
      count_q     <= '0;
      launch_q    <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      launch_q  <= launch_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        set_width_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    if (accept) begin
      cmd_q <= cmd_e'(s_axis_tuser);
      set_q <= s_axis_tdata;
      hit_q <= 1'b0;
    end
    if ((state_q == S_SCAN) && tok_i.valid) begin
      hit_q   <= tok_i.hit;
      hidx_q  <= idx_i;
      hdata_q <= data_i;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count beyond capacity");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (count_q < DepthCnt) && (state_q == S_FINISH))
    else $error("entry write outside finish or on full table");

  a_launch_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> (state_q == S_SCAN))
    else $error("scan token launched outside scan");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid |-> (state_q == S_SCAN))
    else $error("scan token returned outside scan");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FINISH) |=> (count_q == $past(count_q)))
    else $error("entry count changed outside finish");
`endif

endmodule
`default_nettype wire

// File: hdl/unique_bitset_worklist_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Push always: no scan; S_FINISH builds the result word, next word taken in S_IDLE.
// Push if absent, pop, look up: S_SCAN, then S_FINISH; no new word is taken until
// the result word is built; the scan token walks the row of TABLE_DEPTH cells.
// A waiting result word does not block the next scan, only its completion.
// Reset (rst_ni, async low) empties the table and sets set_width to 64;
// entries themselves are not cleared.
// -----------------------------------------------------------------------------
// unique_bitset_worklist_table
// Stack of state sets with first-match search, built as a row of entry cells.
// -----------------------------------------------------------------------------
module unique_bitset_worklist_table
  import ubwt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned SET_BITS    = SetBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InSetW-1:0]    s_axis_tdata,  // set_bits[63:0]
  input  wire logic [CmdW-1:0]      s_axis_tuser,  // command[1:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // match_index[5:0], popped_set[69:6], entry_total[76:70], zero[79:77]
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic [OutUserW-1:0]       m_axis_tuser,  // found[0], status[2:1]
  input  wire logic                 cfg_we_i,
  input  wire logic [WidthW-1:0]    cfg_wdata_i    // set_width[6:0]
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  tok_t                chain_tok  [TABLE_DEPTH+1];
  logic [IdxW-1:0]     chain_idx  [TABLE_DEPTH+1];
  logic [SET_BITS-1:0] chain_data [TABLE_DEPTH+1];
  logic [SET_BITS-1:0] query;
  logic [SET_BITS-1:0] mask;
  logic [CntW-1:0]     count;
  logic [IdxW-1:0]     pop_idx;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [SET_BITS-1:0] wr_data;

  assign chain_idx[0]  = '0;
  assign chain_data[0] = '0;

  ubwt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SET_BITS    (SET_BITS),
    .IDX_W       (IdxW),
    .CNT_W       (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .tok_o         (chain_tok[0]),
    .query_o       (query),
    .mask_o        (mask),
    .count_o       (count),
    .pop_idx_o     (pop_idx),
    .wr_en_o       (wr_en),
    .wr_idx_o      (wr_idx),
    .wr_data_o     (wr_data),
    .tok_i         (chain_tok[TABLE_DEPTH]),
    .idx_i         (chain_idx[TABLE_DEPTH]),
    .data_i        (chain_data[TABLE_DEPTH])
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ubwt_cell #(
      .CELL_INDEX (g),
      .SET_BITS   (SET_BITS),
      .IDX_W      (IdxW),
      .CNT_W      (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain_tok[g]),
      .idx_i     (chain_idx[g]),
      .data_i    (chain_data[g]),
      .query_i   (query),
      .mask_i    (mask),
      .count_i   (count),
      .pop_idx_i (pop_idx),
      .wr_en_i   (wr_en),
      .wr_idx_i  (wr_idx),
      .wr_data_i (wr_data),
      .tok_o     (chain_tok[g+1]),
      .idx_o     (chain_idx[g+1]),
      .data_o    (chain_data[g+1])
    );
  end

endmodule
`default_nettype wire
